[hdl/icv_pkg.sv]
// icv_pkg: shared constants, stream widths and the ones'-complement fold
// for the internet checksum verifier; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package icv_pkg;

    // pseudo-header mode codes, sampled on the first request of a segment
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_IPV4  = 2'd1;
    localparam logic [1:0] MODE_IPV6  = 2'd2;

    localparam logic [15:0] ALL_ONES = 16'hFFFF;

    localparam int S_TDATA_W = 272;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;

    // end-around fold of a sum of up to 256 words; a non-zero input never folds to zero
    function automatic logic [15:0] fold_sum(input logic [23:0] v);
        logic [16:0] a;
        a = {1'b0, v[15:0]} + {9'd0, v[23:16]};
        return a[15:0] + {15'd0, a[16]};
    endfunction

endpackage

`default_nettype wire

[hdl/internet_checksum_verifier_unit.sv]
// a last request passes from the input stage to the result register once the output is free;
// throughput one request per cycle, set by the running-sum update, while no last request
// waits on a stalled result. the result register frees the input side for non-last
// requests while a result waits. reset (aresetn low, synchronous) empties both stages
// and zeroes sum, held byte, odd flag, byte count and mode. uses icv_pkg and icv_pseudo_sum
`timescale 1ns / 1ps
`default_nettype none

module internet_checksum_verifier_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_byte, src_addr_high, src_addr_low, dst_addr_high, dst_addr_low, protocol_number
    input  wire logic [icv_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0], first, byte_valid
    input  wire logic [icv_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // checksum_ok, folded_sum, zero fill
    output logic [icv_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    logic [15:0] ph_sum;

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_first_reg, s1_last_reg, s1_bvalid_reg;
    logic [1:0]  s1_op_reg;
    logic [7:0]  s1_byte_reg;
    logic [15:0] s1_ph_reg;

    // segment state
    logic [15:0]            sum_reg, sum_next;
    logic [7:0]             held_reg, held_next;
    logic                   odd_reg, odd_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [1:0]             mode_reg, mode_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        ok_reg;
    logic [15:0] folded_reg;

    logic        in_take, out_free, s1_adv;
    logic [15:0] sum_base, word_add, pad_add, len_hi, len_lo, ph_add, sum_new;
    logic [7:0]  held_base, held_new;
    logic        odd_base, odd_new;
    logic [LENGTH_BITS-1:0] count_base, count_new;
    logic [31:0] count_ext;
    logic [23:0] total;

    icv_pseudo_sum u_pseudo_sum (
        .mode            (s_axis_tuser[1:0]),
        .src_addr_high   (s_axis_tdata[71:8]),
        .src_addr_low    (s_axis_tdata[135:72]),
        .dst_addr_high   (s_axis_tdata[199:136]),
        .dst_addr_low    (s_axis_tdata[263:200]),
        .protocol_number (s_axis_tdata[271:264]),
        .ph_sum          (ph_sum)
    );

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_comb begin
        mode_next  = s1_first_reg ? s1_op_reg : mode_reg;
        sum_base   = s1_first_reg ? 16'd0 : sum_reg;
        held_base  = s1_first_reg ? 8'd0 : held_reg;
        odd_base   = s1_first_reg ? 1'b0 : odd_reg;
        count_base = s1_first_reg ? '0 : count_reg;
        ph_add     = s1_first_reg ? s1_ph_reg : 16'd0;

        word_add = 16'd0;
        held_new = held_base;
        odd_new  = odd_base;
        if (s1_bvalid_reg) begin
            if (odd_base) begin
                word_add = {held_base, s1_byte_reg};
                held_new = 8'd0;
                odd_new  = 1'b0;
            end else begin
                held_new = s1_byte_reg;
                odd_new  = 1'b1;
            end
        end
        count_new = s1_bvalid_reg ? count_base + LENGTH_BITS'(1) : count_base;
        count_ext = 32'(count_new);

        // odd trailing byte padded with zero, then the length word(s) in ipv4 and ipv6 mode
        pad_add = (s1_last_reg && odd_new) ? {held_new, 8'h00} : 16'd0;
        len_hi  = 16'd0;
        len_lo  = 16'd0;
        if (s1_last_reg) begin
            case (mode_next)
                icv_pkg::MODE_IPV4: begin
                    len_lo = count_ext[15:0];
                end
                icv_pkg::MODE_IPV6: begin
                    len_hi = count_ext[31:16];
                    len_lo = count_ext[15:0];
                end
                default: begin
                    len_lo = 16'd0;
                end
            endcase
        end

        total = {8'd0, sum_base} + {8'd0, ph_add} + {8'd0, word_add}
              + {8'd0, pad_add} + {8'd0, len_hi} + {8'd0, len_lo};
        sum_new = icv_pkg::fold_sum(total);

        if (s1_last_reg) begin
            sum_next   = 16'd0;
            held_next  = 8'd0;
            odd_next   = 1'b0;
            count_next = '0;
        end else begin
            sum_next   = sum_new;
            held_next  = held_new;
            odd_next   = odd_new;
            count_next = count_new;
        end

        if (s1_adv && s1_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sum_reg      <= 16'd0;
            held_reg     <= 8'd0;
            odd_reg      <= 1'b0;
            count_reg    <= '0;
            mode_reg     <= icv_pkg::MODE_PLAIN;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_adv) begin
                sum_reg   <= sum_next;
                held_reg  <= held_next;
                odd_reg   <= odd_next;
                count_reg <= count_next;
                mode_reg  <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_op_reg     <= s_axis_tuser[1:0];
            s1_first_reg  <= s_axis_tuser[2];
            s1_bvalid_reg <= s_axis_tuser[3];
            s1_last_reg   <= s_axis_tlast;
            s1_byte_reg   <= s_axis_tdata[7:0];
            s1_ph_reg     <= ph_sum;
        end
        if (s1_adv && s1_last_reg) begin
            ok_reg     <= (sum_new == icv_pkg::ALL_ONES);
            folded_reg <= sum_new;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, folded_reg, ok_reg};

endmodule

`default_nettype wire

[hdl/icv_pseudo_sum.sv]
// icv_pseudo_sum: folded sum of the pseudo-header addresses and protocol
// for the ipv4 and ipv6 modes; uses icv_pkg
`timescale 1ns / 1ps
`default_nettype none

module icv_pseudo_sum (
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] src_addr_high,
    input  wire logic [63:0] src_addr_low,
    input  wire logic [63:0] dst_addr_high,
    input  wire logic [63:0] dst_addr_low,
    input  wire logic [7:0]  protocol_number,
    output logic      [15:0] ph_sum
);

    logic [20:0] v6_sum;
    logic [18:0] v4_sum;
    logic [23:0] total;

    function automatic logic [17:0] sum4(input logic [63:0] v);
        logic [16:0] a;
        logic [16:0] b;
        a = {1'b0, v[63:48]} + {1'b0, v[47:32]};
        b = {1'b0, v[31:16]} + {1'b0, v[15:0]};
        return {1'b0, a} + {1'b0, b};
    endfunction

    always_comb begin
        v6_sum = {1'b0, {2'b0, sum4(src_addr_high)} + {2'b0, sum4(src_addr_low)}
                      + {2'b0, sum4(dst_addr_high)} + {2'b0, sum4(dst_addr_low)}}
                 + {13'd0, protocol_number};
        v4_sum = {3'd0, src_addr_low[31:16]} + {3'd0, src_addr_low[15:0]}
               + {3'd0, dst_addr_low[31:16]} + {3'd0, dst_addr_low[15:0]}
               + {11'd0, protocol_number};
        case (mode)
            icv_pkg::MODE_IPV4: total = {5'd0, v4_sum};
            icv_pkg::MODE_IPV6: total = {3'd0, v6_sum};
            default:            total = 24'd0;
        endcase
        ph_sum = icv_pkg::fold_sum(total);
    end

endmodule

`default_nettype wire

[hdl/icv_checker.sv]
// icv_checker: port-level assertions for internet_checksum_verifier_unit,
// attached by the bind below; uses icv_pkg
`timescale 1ns / 1ps
`default_nettype none

module icv_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          s_axis_tlast,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [icv_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ok_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[16:1] == icv_pkg::ALL_ONES)))
        else $error("checksum_ok disagrees with folded_sum");

    // a new result comes from a last request that went through the input stage and the result register unstalled
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last request");

    // no waiting result means the input side is open
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind internet_checksum_verifier_unit icv_checker u_icv_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/sv/icv_result_checker.sv]
// icv_result_checker: watches both stream channels of the checksum verifier,
// predicts each segment's folded sum and ok flag, and compares them in order
// depends on icv_pkg for stream widths and mode codes
`timescale 1ns / 1ps
`default_nettype none

module icv_result_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [icv_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [icv_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [icv_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output int                                  fail_count,
    output int                                  outstanding
);

    typedef struct {
        logic        ok;
        logic [15:0] sum;
    } verdict_t;

    verdict_t    due_verdicts[$];

    // predicted segment state
    logic [15:0] sum_acc;
    logic [7:0]  held_byte;
    logic        odd_flag;
    logic [31:0] seg_bytes;
    logic [1:0]  seg_mode;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] ones_add_quad(input logic [15:0] acc,
                                                  input logic [63:0] v);
        logic [15:0] r;
        r = ones_add(acc, v[63:48]);
        r = ones_add(r, v[47:32]);
        r = ones_add(r, v[31:16]);
        return ones_add(r, v[15:0]);
    endfunction

    task automatic clear_segment();
        sum_acc   = '0;
        held_byte = '0;
        odd_flag  = 1'b0;
        seg_bytes = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("icv_result_checker: %0t %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic absorb_request();
        logic [1:0]  op;
        logic        is_first;
        logic        is_valid;
        logic [7:0]  data;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [7:0]  proto;
        verdict_t    v;
        op       = s_axis_tuser[1:0];
        is_first = s_axis_tuser[2];
        is_valid = s_axis_tuser[3];
        data     = s_axis_tdata[7:0];
        src_hi   = s_axis_tdata[71:8];
        src_lo   = s_axis_tdata[135:72];
        dst_hi   = s_axis_tdata[199:136];
        dst_lo   = s_axis_tdata[263:200];
        proto    = s_axis_tdata[271:264];

        if (is_first) begin
            clear_segment();
            seg_mode = op;
            if (seg_mode == icv_pkg::MODE_IPV4) begin
                sum_acc = ones_add(sum_acc, src_lo[31:16]);
                sum_acc = ones_add(sum_acc, src_lo[15:0]);
                sum_acc = ones_add(sum_acc, dst_lo[31:16]);
                sum_acc = ones_add(sum_acc, dst_lo[15:0]);
                sum_acc = ones_add(sum_acc, {8'd0, proto});
            end else if (seg_mode == icv_pkg::MODE_IPV6) begin
                sum_acc = ones_add_quad(sum_acc, src_hi);
                sum_acc = ones_add_quad(sum_acc, src_lo);
                sum_acc = ones_add_quad(sum_acc, dst_hi);
                sum_acc = ones_add_quad(sum_acc, dst_lo);
                sum_acc = ones_add(sum_acc, {8'd0, proto});
            end
        end

        if (is_valid) begin
            if (odd_flag) begin
                sum_acc   = ones_add(sum_acc, {held_byte, data});
                odd_flag  = 1'b0;
                held_byte = '0;
            end else begin
                held_byte = data;
                odd_flag  = 1'b1;
            end
            seg_bytes = seg_bytes + 32'd1;
        end

        if (s_axis_tlast) begin
            // a dangling high byte is padded with a zero low byte
            if (odd_flag)
                sum_acc = ones_add(sum_acc, {held_byte, 8'd0});
            if (seg_mode == icv_pkg::MODE_IPV4) begin
                sum_acc = ones_add(sum_acc, seg_bytes[15:0]);
            end else if (seg_mode == icv_pkg::MODE_IPV6) begin
                sum_acc = ones_add(sum_acc, seg_bytes[31:16]);
                sum_acc = ones_add(sum_acc, seg_bytes[15:0]);
            end
            v.ok  = (sum_acc == icv_pkg::ALL_ONES);
            v.sum = sum_acc;
            due_verdicts.push_back(v);
            // mode survives the result, the rest starts over
            clear_segment();
        end
    endtask

    task automatic check_result();
        verdict_t v;
        if (due_verdicts.size() == 0) begin
            report_mismatch("result with no request pending", 32'(m_axis_tdata), 32'd0);
        end else begin
            v = due_verdicts.pop_front();
            if (m_axis_tdata[0] !== v.ok)
                report_mismatch("checksum_ok", 32'(m_axis_tdata[0]), 32'(v.ok));
            if (m_axis_tdata[16:1] !== v.sum)
                report_mismatch("folded_sum", 32'(m_axis_tdata[16:1]), 32'(v.sum));
            if (m_axis_tdata[23:17] !== 7'd0)
                report_mismatch("zero fill", 32'(m_axis_tdata[23:17]), 32'd0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_segment();
            seg_mode    = icv_pkg::MODE_PLAIN;
            due_verdicts.delete();
            fail_count  = 0;
            outstanding = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                absorb_request();
            outstanding = due_verdicts.size();
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: clock, reset and request stimulus for internet_checksum_verifier_unit,
// with random idling on both channels; checking is done in icv_result_checker
// depends on icv_pkg, the unit under test and icv_result_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    // operation code with no pseudo-header meaning; behaves as plain
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_REQUESTS = 500;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // data_byte, src_addr_high, src_addr_low, dst_addr_high, dst_addr_low, protocol_number
    logic [icv_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    // operation[1:0], first, byte_valid
    logic [icv_pkg::S_TUSER_W-1:0]   s_axis_tuser;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // checksum_ok, folded_sum, zero fill
    logic [icv_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    int fail_count;
    int outstanding;
    int idle_pct;
    int stall_pct;
    int requests_sent;
    int cycle_count;

    internet_checksum_verifier_unit #(
        .LENGTH_BITS(32)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    icv_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_req(input logic [1:0] op, input logic is_first, input logic is_last,
                            input logic is_valid, input logic [7:0] data,
                            input logic [63:0] src_hi, input logic [63:0] src_lo,
                            input logic [63:0] dst_hi, input logic [63:0] dst_lo,
                            input logic [7:0] proto);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {proto, dst_lo, dst_hi, src_lo, src_hi, data};
        s_axis_tuser  <= {is_valid, is_first, op};
        s_axis_tlast  <= is_last;
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_rand(input logic [1:0] op, input logic is_first, input logic is_last,
                             input logic is_valid);
        send_req(op, is_first, is_last, is_valid, 8'($urandom), rand64(), rand64(),
                 rand64(), rand64(), 8'($urandom));
    endtask

    // one well-formed segment; operation is random on non-first requests as it is ignored
    task automatic run_segment(input int nbytes, input logic [1:0] op);
        logic is_first;
        is_first = 1'b1;
        if (nbytes == 0) begin
            send_rand(op, 1'b1, 1'b1, 1'b0);
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(9) == 0) begin
                    send_rand(is_first ? op : 2'($urandom), is_first, 1'b0, 1'b0);
                    is_first = 1'b0;
                end
                send_rand(is_first ? op : 2'($urandom), is_first, i == nbytes - 1, 1'b1);
                is_first = 1'b0;
            end
        end
    endtask

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return icv_pkg::MODE_PLAIN;
        else if (r < 6)
            return icv_pkg::MODE_IPV4;
        else if (r < 9)
            return icv_pkg::MODE_IPV6;
        return MODE_SPARE;
    endfunction

    initial begin
        int target;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        requests_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // nothing started yet: bytes gather in plain mode, operation ignored
        send_req(icv_pkg::MODE_IPV6, 1'b0, 1'b0, 1'b1, 8'hFF, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        send_req(icv_pkg::MODE_IPV4, 1'b0, 1'b1, 1'b1, 8'h00, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        // after a result, carry on without first; single odd byte
        send_req(icv_pkg::MODE_IPV4, 1'b0, 1'b1, 1'b1, 8'hA5, '0, '0, '0, '0, 8'h00);
        // empty one-request segments in every mode
        send_req(icv_pkg::MODE_PLAIN, 1'b1, 1'b1, 1'b0, 8'hFF, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        send_req(icv_pkg::MODE_IPV4, 1'b1, 1'b1, 1'b0, 8'h00, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        send_req(icv_pkg::MODE_IPV6, 1'b1, 1'b1, 1'b0, 8'h00, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        send_req(MODE_SPARE, 1'b1, 1'b1, 1'b0, 8'h00, ONES64, ONES64, ONES64, ONES64, 8'hFF);
        // one-byte segments with pseudo-header
        send_req(icv_pkg::MODE_IPV4, 1'b1, 1'b1, 1'b1, 8'hFF, ONES64, ONES64, ONES64, ONES64,
                 8'hFF);
        send_req(icv_pkg::MODE_IPV6, 1'b1, 1'b1, 1'b1, 8'hFF, '0, '0, '0, '0, 8'h00);
        // all-ones word gives a passing checksum
        send_req(icv_pkg::MODE_PLAIN, 1'b1, 1'b0, 1'b1, 8'hFF, '0, '0, '0, '0, 8'h00);
        send_req(icv_pkg::MODE_PLAIN, 1'b0, 1'b1, 1'b1, 8'hFF, '0, '0, '0, '0, 8'h00);
        // gap in the byte stream, then an odd tail
        send_req(icv_pkg::MODE_IPV6, 1'b1, 1'b0, 1'b1, 8'h12, ONES64, '0, '0, ONES64, 8'h11);
        send_req(icv_pkg::MODE_PLAIN, 1'b0, 1'b0, 1'b0, 8'hFF, '0, '0, '0, '0, 8'h00);
        send_req(icv_pkg::MODE_IPV4, 1'b0, 1'b0, 1'b1, 8'h34, '0, '0, '0, '0, 8'h00);
        send_req(icv_pkg::MODE_PLAIN, 1'b0, 1'b1, 1'b1, 8'h56, '0, '0, '0, '0, 8'h00);
        // restart in the middle of a segment with a byte held
        send_req(icv_pkg::MODE_IPV4, 1'b1, 1'b0, 1'b1, 8'h80, ONES64, ONES64, ONES64, ONES64,
                 8'h06);
        send_req(icv_pkg::MODE_IPV4, 1'b1, 1'b0, 1'b1, 8'h01, '0, 64'hC0A8_0001, '0,
                 64'hC0A8_00FE, 8'h11);
        send_req(icv_pkg::MODE_PLAIN, 1'b0, 1'b1, 1'b1, 8'h02, '0, '0, '0, '0, 8'h00);
        // mode kept after a result, later bytes go on with it
        send_req(icv_pkg::MODE_PLAIN, 1'b0, 1'b1, 1'b1, 8'h7F, '0, '0, '0, '0, 8'h00);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target) begin
                if ($urandom_range(99) < 85) begin
                    run_segment(($urandom_range(19) == 0) ? $urandom_range(300)
                                                          : $urandom_range(40), pick_mode());
                end else begin
                    // loose requests with random first and last
                    repeat ($urandom_range(1, 8))
                        send_rand(2'($urandom), $urandom_range(4) == 0,
                                  $urandom_range(3) == 0, 1'($urandom));
                end
            end
        end

        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
